// ----- rtl/etrs_pkg.sv -----
// Shared types and constants for the Euler translate/rotate/scale transform core.
// No dependencies.
`timescale 1ns / 1ps

package etrs_pkg;

	typedef logic signed [33:0] q30_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         row_kind;
		logic signed [31:0] elem_0;
		logic signed [31:0] elem_1;
		logic signed [31:0] elem_2;
		logic signed [31:0] elem_3;
		logic               last_row;
	} out_item_t;

	localparam logic [2:0] ROW_M0      = 3'd0;
	localparam logic [2:0] ROW_M3      = 3'd3;
	localparam logic [2:0] ROW_RIGHT   = 3'd4;
	localparam logic [2:0] ROW_FORWARD = 3'd6;

	localparam q30_t CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [40:0] UNIT_TO_RAD = 41'sd74961321;
	localparam logic [16:0] TURN       = 17'd23040;
	localparam logic [16:0] TWO_TURNS  = 17'd46080;
	localparam logic signed [15:0] HALF_TURN    = 16'sd11520;
	localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;

	function automatic q30_t atan_q30(input int idx);
		case (idx)
			0: atan_q30 = 34'sd843314857;
			1: atan_q30 = 34'sd497837829;
			2: atan_q30 = 34'sd263043837;
			3: atan_q30 = 34'sd133525159;
			4: atan_q30 = 34'sd67021687;
			5: atan_q30 = 34'sd33543516;
			6: atan_q30 = 34'sd16775851;
			7: atan_q30 = 34'sd8388437;
			8: atan_q30 = 34'sd4194283;
			9: atan_q30 = 34'sd2097149;
			default: atan_q30 = q30_t'(34'sd1 <<< (30 - idx));
		endcase
	endfunction

endpackage

// ----- rtl/euler_trs_transform_core.sv -----
// Euler translate/rotate/scale model matrix core: angle folding, three CORDIC
// pipelines, rotation product stages and a row sequencer. Uses etrs_pkg.
// The seven rows of an item follow on consecutive cycles. The issue counter
// keeps busy high after each accepted item so that items do not overlap on the single
// result channel; start is ignored while busy is high.
// Reset (arst_n low, asynchronous) clears all valid bits, the row sequencer
// and busy. The receiver cannot stall; every strobe delivers one row.
`timescale 1ns / 1ps

module euler_trs_transform_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  etrs_pkg::in_item_t  src,
	output logic                strobe,
	output etrs_pkg::out_item_t result
);

	localparam int N = CORDIC_STEPS;

	typedef struct packed {
		logic signed [13:0] ang;
		logic               neg;
	} fold_t;

	function automatic fold_t fold_angle(input logic signed [15:0] ang);
		logic [16:0] v;
		logic signed [15:0] b;
		fold_t r;
		v = 17'(unsigned'(17'(ang)) + etrs_pkg::TWO_TURNS);
		if (v >= etrs_pkg::TWO_TURNS) v = v - etrs_pkg::TWO_TURNS;
		if (v >= etrs_pkg::TURN) v = v - etrs_pkg::TURN;
		b = signed'(v[15:0]);
		if (b > etrs_pkg::HALF_TURN) b = b - 16'(etrs_pkg::TURN);
		r.neg = 1'b0;
		if (b > etrs_pkg::QUARTER_TURN) begin
			b = etrs_pkg::HALF_TURN - b;
			r.neg = 1'b1;
		end else if (b < -etrs_pkg::QUARTER_TURN) begin
			b = -etrs_pkg::HALF_TURN - b;
			r.neg = 1'b1;
		end
		r.ang = b[13:0];
		return r;
	endfunction

	function automatic etrs_pkg::q30_t mul30(input etrs_pkg::q30_t a, input etrs_pkg::q30_t b);
		logic signed [67:0] p;
		p = a * b;
		p = p + 68'sd536870912;
		return etrs_pkg::q30_t'(p >>> 30);
	endfunction

	// Issue control: a down-counter keeps busy high after each accepted item.
	logic [2:0] cnt_q;
	logic       accept;
	assign accept = start && !busy;
	assign busy   = (cnt_q != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 3'd0;
		else if (accept) cnt_q <= 3'd6;
		else if (cnt_q != 3'd0) cnt_q <= cnt_q - 3'd1;
	end

	// Stage 1: fold angles into the first half turn around zero.
	logic               v_s1;
	etrs_pkg::in_item_t pl_s1;
	fold_t              fa_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pl_s1    <= src;
			fa_s1[0] <= fold_angle(src.angle_x);
			fa_s1[1] <= fold_angle(src.angle_y);
			fa_s1[2] <= fold_angle(src.angle_z);
		end
	end

	// CORDIC pipeline: index 0 holds the initial vector, index k+1 the result of step k.
	logic               v_sc   [N+1];
	etrs_pkg::in_item_t pl_sc  [N+1];
	logic               neg_sc [N+1][3];
	etrs_pkg::q30_t     x_sc   [N+1][3];
	etrs_pkg::q30_t     y_sc   [N+1][3];
	etrs_pkg::q30_t     z_sc   [N+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sc[0] <= 1'b0;
		else v_sc[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		pl_sc[0] <= pl_s1;
		for (int a = 0; a < 3; a++) begin
			logic signed [40:0] p;
			p = 41'(fa_s1[a].ang) * etrs_pkg::UNIT_TO_RAD + 41'sd128;
			z_sc[0][a]   <= etrs_pkg::q30_t'(p >>> 8);
			x_sc[0][a]   <= etrs_pkg::CORDIC_GAIN;
			y_sc[0][a]   <= '0;
			neg_sc[0][a] <= fa_s1[a].neg;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sc[k+1] <= 1'b0;
			else v_sc[k+1] <= v_sc[k];
		end
		always_ff @(posedge clk) begin
			pl_sc[k+1] <= pl_sc[k];
			for (int a = 0; a < 3; a++) begin
				neg_sc[k+1][a] <= neg_sc[k][a];
				if (!z_sc[k][a][33]) begin
					x_sc[k+1][a] <= x_sc[k][a] - (y_sc[k][a] >>> k);
					y_sc[k+1][a] <= y_sc[k][a] + (x_sc[k][a] >>> k);
					z_sc[k+1][a] <= z_sc[k][a] - etrs_pkg::atan_q30(k);
				end else begin
					x_sc[k+1][a] <= x_sc[k][a] + (y_sc[k][a] >>> k);
					y_sc[k+1][a] <= y_sc[k][a] - (x_sc[k][a] >>> k);
					z_sc[k+1][a] <= z_sc[k][a] + etrs_pkg::atan_q30(k);
				end
			end
		end
	end

	etrs_pkg::q30_t sx, cx, sy, cy, sz, cz;
	assign sx = y_sc[N][0];
	assign sy = y_sc[N][1];
	assign sz = y_sc[N][2];
	assign cx = neg_sc[N][0] ? -x_sc[N][0] : x_sc[N][0];
	assign cy = neg_sc[N][1] ? -x_sc[N][1] : x_sc[N][1];
	assign cz = neg_sc[N][2] ? -x_sc[N][2] : x_sc[N][2];

	// Product stage: the pairwise trig products that the rotation matrix needs.
	logic               v_m1;
	etrs_pkg::in_item_t pl_m1;
	etrs_pkg::q30_t sxsy_m1, cxsy_m1, cycz_m1, cysz_m1, cxsz_m1, cxcz_m1;
	etrs_pkg::q30_t sxcy_m1, sxsz_m1, sxcz_m1, cxcy_m1, sy_m1, sz_m1, cz_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m1 <= 1'b0;
		else v_m1 <= v_sc[N];
	end

	always_ff @(posedge clk) begin
		pl_m1   <= pl_sc[N];
		sxsy_m1 <= mul30(sx, sy);
		cxsy_m1 <= mul30(cx, sy);
		cycz_m1 <= mul30(cy, cz);
		cysz_m1 <= mul30(cy, sz);
		cxsz_m1 <= mul30(cx, sz);
		cxcz_m1 <= mul30(cx, cz);
		sxcy_m1 <= mul30(sx, cy);
		sxsz_m1 <= mul30(sx, sz);
		sxcz_m1 <= mul30(sx, cz);
		cxcy_m1 <= mul30(cx, cy);
		sy_m1   <= sy;
		sz_m1   <= sz;
		cz_m1   <= cz;
	end

	// Rotation matrix stage.
	logic               v_m2;
	etrs_pkg::in_item_t pl_m2;
	etrs_pkg::q30_t     r_m2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m2 <= 1'b0;
		else v_m2 <= v_m1;
	end

	always_ff @(posedge clk) begin
		pl_m2      <= pl_m1;
		r_m2[0][0] <= cycz_m1;
		r_m2[0][1] <= -cysz_m1;
		r_m2[0][2] <= sy_m1;
		r_m2[1][0] <= mul30(sxsy_m1, cz_m1) + cxsz_m1;
		r_m2[1][1] <= cxcz_m1 - mul30(sxsy_m1, sz_m1);
		r_m2[1][2] <= -sxcy_m1;
		r_m2[2][0] <= sxsz_m1 - mul30(cxsy_m1, cz_m1);
		r_m2[2][1] <= mul30(cxsy_m1, sz_m1) + sxcz_m1;
		r_m2[2][2] <= cxcy_m1;
	end

	// Row sequencer: holds one item's matrix while its seven rows go out.
	etrs_pkg::q30_t     r_q   [3][3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] scl_q [3];
	logic               act_q;
	logic [2:0]         row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			row_q <= etrs_pkg::ROW_M0;
		end else if (v_m2) begin
			act_q <= 1'b1;
			row_q <= etrs_pkg::ROW_M0;
		end else if (act_q) begin
			if (row_q == etrs_pkg::ROW_FORWARD) act_q <= 1'b0;
			else row_q <= row_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_m2) begin
			r_q      <= r_m2;
			pos_q[0] <= pl_m2.pos_x;
			pos_q[1] <= pl_m2.pos_y;
			pos_q[2] <= pl_m2.pos_z;
			scl_q[0] <= pl_m2.scale_x;
			scl_q[1] <= pl_m2.scale_y;
			scl_q[2] <= pl_m2.scale_z;
		end
	end

	// Element product stage. Axis rows are scaled by 2^FRAC_BITS so that both
	// row kinds share the same rounding shift by 30.
	logic               v_p;
	logic [2:0]         row_p;
	logic signed [65:0] prod_p [3];
	logic signed [31:0] e3_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p <= 1'b0;
		else v_p <= act_q;
	end

	always_ff @(posedge clk) begin
		row_p <= row_q;
		for (int j = 0; j < 3; j++) begin
			if (row_q < etrs_pkg::ROW_M3) begin
				prod_p[j] <= r_q[row_q[1:0]][j] * scl_q[j];
			end else if (row_q == etrs_pkg::ROW_M3) begin
				prod_p[j] <= '0;
			end else begin
				prod_p[j] <= 66'(r_q[j][2'(row_q - etrs_pkg::ROW_RIGHT)]) <<< FRAC_BITS;
			end
		end
		if (row_q < etrs_pkg::ROW_M3) e3_p <= pos_q[row_q[1:0]];
		else if (row_q == etrs_pkg::ROW_M3) e3_p <= 32'sd1 <<< FRAC_BITS;
		else e3_p <= '0;
	end

	function automatic logic signed [31:0] round_sat(input logic signed [65:0] p);
		logic signed [65:0] t;
		logic signed [35:0] s;
		t = p + 66'sd536870912;
		s = 36'(t >>> 30);
		if (s > 36'sd2147483647) return 32'sh7fffffff;
		if (s < -36'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= v_p;
	end

	always_ff @(posedge clk) begin
		result.row_kind <= row_p;
		result.elem_0   <= round_sat(prod_p[0]);
		result.elem_1   <= round_sat(prod_p[1]);
		result.elem_2   <= round_sat(prod_p[2]);
		result.elem_3   <= e3_p;
		result.last_row <= (row_p == etrs_pkg::ROW_FORWARD);
	end

endmodule

// ----- rtl/etrs_checker.sv -----
// Port-level checker for euler_trs_transform_core, bound into that module.
// Uses etrs_pkg for the row codes.
`timescale 1ns / 1ps

module etrs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                strobe,
	input etrs_pkg::out_item_t result
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	a_last_on_forward: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last_row == (result.row_kind == etrs_pkg::ROW_FORWARD)))
		else $error("last_row does not match the forward axis row");

	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_row |=>
			strobe && (result.row_kind == $past(result.row_kind) + 3'd1))
		else $error("result rows not consecutive");

endmodule

bind euler_trs_transform_core etrs_checker u_etrs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);

// ----- dv/tb_euler_trs_transform_core.sv -----
// Self-checking testbench for euler_trs_transform_core: predicts the seven rows
// of every accepted item and checks each strobed row in order. Uses etrs_pkg.
`timescale 1ns / 1ps

module tb_euler_trs_transform_core;

	localparam int STEPS = 16;
	localparam int FRAC = 16;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	etrs_pkg::in_item_t src = '0;
	logic strobe;
	etrs_pkg::out_item_t result;

	etrs_pkg::out_item_t pending_rows[$];
	int mismatches = 0;
	int stall_cycles = 0;
	bit allow_gaps = 1'b1;

	longint atan_tab[30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	euler_trs_transform_core #(.CORDIC_STEPS(STEPS), .FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.src(src), .strobe(strobe), .result(result));

	always #10 clk = ~clk;

	function automatic longint rnd_shift(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint qmul(longint a, longint b);
		return rnd_shift(a * b, 30);
	endfunction

	// Folds the angle into [-90, 90] degrees and runs the rotation-mode CORDIC.
	task automatic angle_sincos(input longint units, output longint s, output longint c);
		longint a, x, y, z, dx, dy;
		bit flip;
		a = units % 23040;
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (a < 0)
			a += 23040;
		if (a > 11520)
			a -= 23040;
		if (a > 5760) begin
			a = 11520 - a;
			flip = 1'b1;
		end else if (a < -5760) begin
			a = -11520 - a;
			flip = 1'b1;
		end
		z = rnd_shift(a * 74961321, 8);
		for (int i = 0; i < STEPS && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		s = y;
		c = flip ? -x : x;
	endtask

	task automatic predict_rows(input etrs_pkg::in_item_t it);
		longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
		longint r[3][3];
		longint pos[3], scl[3];
		etrs_pkg::out_item_t row;
		pos = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
		scl = '{longint'(it.scale_x), longint'(it.scale_y), longint'(it.scale_z)};
		angle_sincos(longint'(it.angle_x), sx, cx);
		angle_sincos(longint'(it.angle_y), sy, cy);
		angle_sincos(longint'(it.angle_z), sz, cz);
		sxsy = qmul(sx, sy);
		cxsy = qmul(cx, sy);
		r[0][0] = qmul(cy, cz);
		r[0][1] = -qmul(cy, sz);
		r[0][2] = sy;
		r[1][0] = qmul(sxsy, cz) + qmul(cx, sz);
		r[1][1] = qmul(cx, cz) - qmul(sxsy, sz);
		r[1][2] = -qmul(sx, cy);
		r[2][0] = qmul(sx, sz) - qmul(cxsy, cz);
		r[2][1] = qmul(cxsy, sz) + qmul(sx, cz);
		r[2][2] = qmul(cx, cy);
		for (int i = 0; i < 3; i++) begin
			row.row_kind = etrs_pkg::ROW_M0 + 3'(i);
			row.elem_0 = clamp32(rnd_shift(r[i][0] * scl[0], 30));
			row.elem_1 = clamp32(rnd_shift(r[i][1] * scl[1], 30));
			row.elem_2 = clamp32(rnd_shift(r[i][2] * scl[2], 30));
			row.elem_3 = clamp32(pos[i]);
			row.last_row = 1'b0;
			pending_rows.push_back(row);
		end
		row = '{etrs_pkg::ROW_M3, 32'sd0, 32'sd0, 32'sd0, 32'sd1 <<< FRAC, 1'b0};
		pending_rows.push_back(row);
		for (int j = 0; j < 3; j++) begin
			row.row_kind = etrs_pkg::ROW_RIGHT + 3'(j);
			row.elem_0 = clamp32(rnd_shift(r[0][j], 30 - FRAC));
			row.elem_1 = clamp32(rnd_shift(r[1][j], 30 - FRAC));
			row.elem_2 = clamp32(rnd_shift(r[2][j], 30 - FRAC));
			row.elem_3 = 32'sd0;
			row.last_row = (row.row_kind == etrs_pkg::ROW_FORWARD);
			pending_rows.push_back(row);
		end
	endtask

	// Called at a rising edge; unless it adds a random gap, leaves start high so a
	// following item can go back to back without start dropping.
	task automatic send_item(input etrs_pkg::in_item_t it);
		int gap;
		start <= 1'b1;
		src <= it;
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
		predict_rows(it);
		if (allow_gaps && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			src <= etrs_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, 16'($urandom)});
			repeat (gap)
				@(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'($urandom);
			1: return 16'sd5760 * $signed(16'($urandom_range(0, 8))) - 16'sd23040;
			default: return 16'($signed($urandom_range(0, 46079)) - 23040);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_q(bit wide);
		if (wide || $urandom_range(0, 3) == 0)
			return 32'($urandom);
		return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
	endfunction

	function automatic etrs_pkg::in_item_t rand_item();
		etrs_pkg::in_item_t it;
		bit wide;
		wide = ($urandom_range(0, 4) == 0);
		it.pos_x = pick_q(1'b1);
		it.pos_y = pick_q(1'b1);
		it.pos_z = pick_q(1'b1);
		it.angle_x = pick_angle();
		it.angle_y = pick_angle();
		it.angle_z = pick_angle();
		it.scale_x = pick_q(wide);
		it.scale_y = pick_q(wide);
		it.scale_z = pick_q(wide);
		return it;
	endfunction

	task automatic test_directed();
		logic signed [15:0] angles[12] = '{
			0, -23040, 23039, 5760, -5760, 11520, -11520,
			5759, 5761, -32768, 32767, 17280};
		etrs_pkg::in_item_t it;
		foreach (angles[k]) begin
			it = '{32'sd0, 32'sd0, 32'sd0, angles[k], angles[(k + 3) % 12],
				angles[(k + 7) % 12], 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
			send_item(it);
		end
		// Extreme positions and scales, where scaled elements saturate, then all-ones and all-zero items.
		send_item('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
		send_item('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sd2880, 16'sd2880,
			16'sd2880, 32'sh80000000, 32'sh7fffffff, 32'sh80000000});
		send_item('{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd11520,
			-16'sd11520, 16'sd5760, 32'sh80000000, 32'sh80000000, 32'sh80000000});
		send_item('{-32'sd1, -32'sd1, -32'sd1, -16'sd1, -16'sd1, -16'sd1,
			-32'sd1, -32'sd1, -32'sd1});
		send_item('0);
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			if (n == count - 60)
				allow_gaps = 1'b0;
			send_item(rand_item());
		end
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row: kind %0d", result.row_kind);
			end else begin
				etrs_pkg::out_item_t exp_row;
				exp_row = pending_rows.pop_front();
				if (result !== exp_row) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row mismatch: exp %0d %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0d %0b",
							exp_row.row_kind, exp_row.elem_0, exp_row.elem_1,
							exp_row.elem_2, exp_row.elem_3, exp_row.last_row,
							result.row_kind, result.elem_0, result.elem_1,
							result.elem_2, result.elem_3, result.last_row);
				end
			end
		end
	end

	// Watchdog on cycles in which neither an item nor a row is accepted.
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(270);
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
